>>> src/upd_pkg.sv
// Shared types, character codes and helper functions of the URL percent decoder.
package upd_pkg;

   localparam logic [7:0] CHAR_PCT  = 8'h25;
   localparam logic [7:0] CHAR_0    = 8'h30;
   localparam logic [7:0] CHAR_9    = 8'h39;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_F    = 8'h46;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] DIGIT_BASE  = 8'd48;
   localparam logic [7:0] LETTER_BASE = 8'd65;
   localparam logic [7:0] LETTER_OFS  = 8'd10;

   localparam int          BUNDLE_CHARS = 4;
   localparam int          IDX_W        = $clog2(BUNDLE_CHARS);
   localparam int          CNT_W        = IDX_W + 1;
   localparam logic [CNT_W-1:0] MAX_EMIT = CNT_W'(BUNDLE_CHARS);

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_PCT     = 6'b000010,
      PH_HEX1    = 6'b000100,
      PH_CR      = 6'b001000,
      PH_CR_PCT  = 6'b010000,
      PH_CR_PCT0 = 6'b100000
   } phase_type;

   // All decoded bytes produced by one input byte, oldest in slot 0.
   typedef struct packed {
      logic [BUNDLE_CHARS-1:0][7:0] chars;
      logic [CNT_W-1:0]             cnt;
      logic                         last;
   } bundle_type;

   typedef struct packed {
      logic [7:0] char_val;
      logic       last;
   } result_type;

   function automatic logic is_hex(logic [7:0] c);
      return c inside {[CHAR_0:CHAR_9], [CHAR_A:CHAR_F]};
   endfunction

   function automatic logic [3:0] hex_val(logic [7:0] c);
      logic [7:0] v;
      if (c > CHAR_9) begin
         v = c - LETTER_BASE + LETTER_OFS;
      end else begin
         v = c - DIGIT_BASE;
      end
      return v[3:0];
   endfunction

   function automatic logic [7:0] nibble_char(logic [3:0] n);
      logic [7:0] r;
      if (n < 4'd10) begin
         r = DIGIT_BASE + {4'd0, n};
      end else begin
         r = LETTER_BASE + {4'd0, n} - LETTER_OFS;
      end
      return r;
   endfunction

   // Add one byte at the tail of a bundle; bytes beyond the capacity drop.
   function automatic bundle_type append(bundle_type b, logic [7:0] ch);
      bundle_type r;
      r = b;
      if (r.cnt < MAX_EMIT) begin
         r.chars[r.cnt[IDX_W-1:0]] = ch;
         r.cnt = r.cnt + CNT_W'(1);
      end
      return r;
   endfunction

endpackage

>>> src/url_percent_decoder.sv
// Top level of the streaming URL percent decoder.
//
// Input channel: one raw byte per transfer on req_char, req_last marks the
// final byte of a string; a transfer happens when req_push is high and
// req_full is low. Result channel: rsp_char/rsp_last show the oldest decoded
// byte while rsp_empty is low; rsp_pop takes it. rsp_last is set on the final
// decoded byte of a string.
// The front end scans each byte in the cycle it arrives and writes the 1 to 4
// bytes it yields, if any, as one bundle into a two-entry queue; the back end
// drains a bundle one byte per cycle, while the result queue can take it, into
// a two-entry result queue. A decoded byte is registered in the bundle queue,
// then in the result queue. Throughput: one input byte per cycle while each
// byte yields at most one result; a bundle holds the back end until all its
// bytes are drained, so a flush of a held escape or CR can stall the input.
// Reset: both queues empty, no escape or CR held.
// When the receiver stops popping, the result queue and then the bundle
// queue fill, and req_full rises; nothing is lost.
module url_percent_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char,
   input  logic       req_last,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_char,
   output logic       rsp_last
);
   import upd_pkg::*;

   localparam int BNDL_W = $bits(bundle_type);
   localparam int RES_W  = $bits(result_type);

   logic       in_accept;
   logic       bndl_push, bndl_pop, bndl_full, bndl_empty;
   bundle_type bndl_wr, bndl_rd;
   logic       res_push, res_full, res_ready;
   result_type res_wr, res_rd;

   // Take a byte whenever the bundle queue has room.
   assign req_full  = bndl_full;
   assign in_accept = req_push && !bndl_full;

   upd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (in_accept),
      .in_char   (req_char),
      .in_last   (req_last),
      .bndl_push (bndl_push),
      .bndl      (bndl_wr)
   );

   upd_queue #(.WIDTH(BNDL_W)) u_bndl_q (
      .clock     (clock),
      .reset     (reset),
      .push      (bndl_push),
      .push_data (bndl_wr),
      .full      (bndl_full),
      .pop       (bndl_pop),
      .pop_data  (bndl_rd),
      .empty     (bndl_empty)
   );

   // Advance the back end when the result queue has room or is being popped.
   assign res_ready = !res_full || rsp_pop;

   upd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .bndl_empty (bndl_empty),
      .bndl       (bndl_rd),
      .bndl_pop   (bndl_pop),
      .out_ready  (res_ready),
      .out_push   (res_push),
      .out_item   (res_wr)
   );

   upd_queue #(.WIDTH(RES_W)) u_res_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_wr),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_rd),
      .empty     (rsp_empty)
   );

   assign rsp_char = res_rd.char_val;
   assign rsp_last = res_rd.last;

`ifndef SYNTHESIS
   // The last byte of a string always yields a bundle carrying the end mark.
   a_last_yields_bundle : assert property (@(posedge clock) disable iff (reset)
      in_accept && req_last |-> bndl_push && bndl_wr.last)
      else $error("last input byte produced no final bundle");

   // The front end never writes into a full bundle queue.
   a_no_bundle_overflow : assert property (@(posedge clock) disable iff (reset)
      bndl_push |-> !bndl_full)
      else $error("bundle queue overflow");

   // After reset nothing is waiting on either side.
   a_reset_clear : assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not cleared by reset");
`endif

endmodule

>>> src/upd_queue.sv
// Two-entry register queue that takes a push into a full queue when it is popped in the same cycle.
module upd_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [1:0][WIDTH-1:0] mem_ff;
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  do_push, do_pop;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;
   assign do_push  = push && (!full || do_pop);

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/upd_front.sv
// Front end: scans each accepted byte and forms the bundle of decoded bytes.
module upd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_char,
   input  logic                  in_last,
   output logic                  bndl_push,
   output upd_pkg::bundle_type   bndl
);
   import upd_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] hn_ff, hn_in;

   always_comb begin
      bundle_type b;
      logic       run_pct, run_hex1, run_idle;
      logic [3:0] work_hn;
      logic [7:0] dec;

      b        = '0;
      phase_in = phase_ff;
      hn_in    = hn_ff;
      run_pct  = 1'b0;
      run_hex1 = 1'b0;
      run_idle = 1'b0;
      work_hn  = hn_ff;
      dec      = {hn_ff, hex_val(in_char)};

      // Resolve a held escape or CR first; a held CR may hand the byte on to escape scanning.
      case (phase_ff)
         PH_PCT: begin
            run_pct = 1'b1;
         end
         PH_HEX1: begin
            run_hex1 = 1'b1;
         end
         PH_CR: begin
            if (in_char == CHAR_PCT) begin
               phase_in = PH_CR_PCT;
            end else begin
               b        = append(b, CHAR_CR);
               run_idle = 1'b1;
            end
         end
         PH_CR_PCT: begin
            if (in_char == CHAR_0) begin
               phase_in = PH_CR_PCT0;
            end else begin
               b       = append(b, CHAR_CR);
               run_pct = 1'b1;
            end
         end
         PH_CR_PCT0: begin
            if (in_char == CHAR_A) begin
               b        = append(b, CHAR_LF);
               phase_in = PH_IDLE;
            end else begin
               b        = append(b, CHAR_CR);
               run_hex1 = 1'b1;
               work_hn  = 4'd0;
               hn_in    = 4'd0;
            end
         end
         default: begin
            run_idle = 1'b1;
         end
      endcase

      if (run_pct) begin
         if (is_hex(in_char)) begin
            hn_in    = hex_val(in_char);
            phase_in = PH_HEX1;
         end else begin
            b        = append(b, CHAR_PCT);
            run_idle = 1'b1;
         end
      end

      if (run_hex1) begin
         dec = {work_hn, hex_val(in_char)};
         if (is_hex(in_char)) begin
            if (dec == CHAR_CR) begin
               phase_in = PH_CR;
            end else begin
               b        = append(b, dec);
               phase_in = PH_IDLE;
            end
         end else begin
            b        = append(b, CHAR_PCT);
            b        = append(b, nibble_char(work_hn));
            run_idle = 1'b1;
         end
      end

      if (run_idle) begin
         if (in_char == CHAR_PCT) begin
            phase_in = PH_PCT;
         end else begin
            b        = append(b, in_char);
            phase_in = PH_IDLE;
         end
      end

      // End of string: release whatever is held, literally.
      if (in_last) begin
         case (phase_in)
            PH_PCT: begin
               b = append(b, CHAR_PCT);
            end
            PH_HEX1: begin
               b = append(b, CHAR_PCT);
               b = append(b, nibble_char(hn_in));
            end
            PH_CR: begin
               b = append(b, CHAR_CR);
            end
            PH_CR_PCT: begin
               b = append(b, CHAR_CR);
               b = append(b, CHAR_PCT);
            end
            PH_CR_PCT0: begin
               b = append(b, CHAR_CR);
               b = append(b, CHAR_PCT);
               b = append(b, CHAR_0);
            end
            default: begin
            end
         endcase
         phase_in = PH_IDLE;
      end

      b.last    = in_last;
      bndl      = b;
      bndl_push = accept && (b.cnt != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hn_ff    <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hn_ff    <= hn_in;
      end
   end

endmodule

>>> src/upd_back.sv
// Back end: drains queued bundles one decoded byte per cycle while the result queue can take it.
module upd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  bndl_empty,
   input  upd_pkg::bundle_type   bndl,
   output logic                  bndl_pop,
   input  logic                  out_ready,
   output logic                  out_push,
   output upd_pkg::result_type   out_item
);
   import upd_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             at_end;

   assign at_end   = ({1'b0, idx_ff} + CNT_W'(1)) == bndl.cnt;
   assign out_push = !bndl_empty && out_ready;
   assign bndl_pop = out_push && at_end;

   always_comb begin
      out_item.char_val = bndl.chars[idx_ff];
      out_item.last     = bndl.last && at_end;
      idx_in            = idx_ff;
      if (bndl_pop) begin
         idx_in = '0;
      end else if (out_push) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
